@@ rtl/kvlt_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the key/value line tokenizer
// no dependencies; used by every kvlt module and the top level

package kvlt_pkg;

  localparam int KEY_BYTES = 8;
  localparam int CHAR_W    = 8;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 8;
  localparam int VALUE_W   = 64;
  localparam int DIGIT_W   = 4;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [6:0] {
    PH_PREFIX1 = 7'b0000001,
    PH_PREFIX2 = 7'b0000010,
    PH_BLANKS  = 7'b0000100,
    PH_KEY     = 7'b0001000,
    PH_DISCARD = 7'b0010000,
    PH_VALUE   = 7'b0100000,
    PH_REJECT  = 7'b1000000
  } phase_t;

  // one input beat as held in the input register
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eol;
  } beat_t;

  typedef struct packed {
    logic                      pair_valid;
    logic [KEY_W-1:0]          key_bytes;
    logic [LEN_W-1:0]          key_length;
    logic                      key_truncated;
    logic signed [VALUE_W-1:0] pair_value;
    logic                      line_end;
    logic                      line_accepted;
  } result_t;

endpackage

@@ rtl/key_value_line_tokenizer.sv @@
`timescale 1ns / 1ps
// Splits "//"-prefixed text lines, fed one byte per beat, into key=value pairs and
// emits each pair with its packed key and parsed signed 64-bit value; every line's last
// byte also yields a result beat carrying line_end and line_accepted. One byte is taken
// every cycle unless in_stall is high; a byte is held in the input register and is then
// parsed into the result register, which offers its result to the sink. The rate is set
// by the parser update, whose longest path is the multiply-by-ten-and-add of the value
// accumulator.
// Bytes that complete nothing are absorbed without a result beat.

module key_value_line_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_in,
  input  logic               end_of_line,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pair_valid,
  output logic [63:0]        key_bytes,
  output logic [7:0]         key_length,
  output logic               key_truncated,
  output logic signed [63:0] pair_value,
  output logic               line_end,
  output logic               line_accepted
);

  kvlt_pkg::beat_t   beat;
  kvlt_pkg::result_t parse_result;
  kvlt_pkg::result_t out_result;
  logic              beat_valid;
  logic              produce;
  logic              take;
  logic              advance;

  // a beat that makes no result never waits on the sink
  assign advance = beat_valid & (~produce | take);

  kvlt_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .char_in     (char_in),
    .end_of_line (end_of_line),
    .in_stall    (in_stall),
    .advance     (advance),
    .beat_valid  (beat_valid),
    .beat        (beat)
  );

  kvlt_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .advance (advance),
    .produce (produce),
    .result  (parse_result)
  );

  kvlt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance & produce),
    .result_in (parse_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .take      (take),
    .result    (out_result)
  );

  assign pair_valid    = out_result.pair_valid;
  assign key_bytes     = out_result.key_bytes;
  assign key_length    = out_result.key_length;
  assign key_truncated = out_result.key_truncated;
  assign pair_value    = out_result.pair_value;
  assign line_end      = out_result.line_end;
  assign line_accepted = out_result.line_accepted;

`ifndef SYNTH
  a_pair_needs_line : assert property (@(posedge clk) disable iff (rst)
    (out_valid && pair_valid) |-> line_accepted)
    else $error("pair emitted on a rejected line");

  a_no_pair_is_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pair_valid) |-> (line_end && key_length == '0 && pair_value == '0))
    else $error("result without pair is not an empty line end");

  a_trunc_len : assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_truncated) |-> (key_length > 8'(kvlt_pkg::KEY_BYTES)))
    else $error("truncated key with short length");

  a_stall_held : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (beat_valid && !advance))
    else $error("input stalled while the input register drains");
`endif

endmodule

@@ rtl/kvlt_in_stage.sv @@
`timescale 1ns / 1ps
// input register for the tokenizer: holds one byte beat until the parser takes it
// depends on kvlt_pkg

module kvlt_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     char_in,
  input  logic           end_of_line,
  output logic           in_stall,
  input  logic           advance,
  output logic           beat_valid,
  output kvlt_pkg::beat_t beat
);

  logic load;

  assign in_stall = beat_valid & ~advance;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (load) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat.ch  <= char_in;
      beat.eol <= end_of_line;
    end
  end

endmodule

@@ rtl/kvlt_parse.sv @@
`timescale 1ns / 1ps
// line parser state and its combinational update for one byte
// depends on kvlt_pkg; produces the result for the output register

module kvlt_parse (
  input  logic              clk,
  input  logic              rst,
  input  kvlt_pkg::beat_t   beat,
  input  logic              advance,
  output logic              produce,
  output kvlt_pkg::result_t result
);

  kvlt_pkg::phase_t               phase, phase_next;
  logic [kvlt_pkg::KEY_W-1:0]     key_buffer, key_buffer_next;
  logic [kvlt_pkg::LEN_W-1:0]     key_count, key_count_next;
  logic                           key_overflow, key_overflow_next;
  logic [kvlt_pkg::VALUE_W-1:0]   value_acc, value_acc_next;
  logic                           value_negative, value_negative_next;
  logic                           value_seen, value_seen_next;
  logic                           digits_stopped, digits_stopped_next;

  logic                           emit;
  logic                           push_key;
  logic                           accepted;
  logic                           is_digit;
  logic [kvlt_pkg::DIGIT_W-1:0]   digit;
  logic [kvlt_pkg::VALUE_W-1:0]   digit_ext;
  logic [kvlt_pkg::VALUE_W-1:0]   digit_term;

  assign is_digit   = (beat.ch >= kvlt_pkg::CH_ZERO) && (beat.ch <= kvlt_pkg::CH_NINE);
  assign digit      = kvlt_pkg::DIGIT_W'(beat.ch - kvlt_pkg::CH_ZERO);
  assign digit_ext  = kvlt_pkg::VALUE_W'(digit);
  // accumulator keeps the signed value, so a negative number subtracts each digit
  assign digit_term = value_negative ? (kvlt_pkg::VALUE_W'(0) - digit_ext) : digit_ext;

  always_comb begin
    phase_next          = phase;
    key_buffer_next     = key_buffer;
    key_count_next      = key_count;
    key_overflow_next   = key_overflow;
    value_acc_next      = value_acc;
    value_negative_next = value_negative;
    value_seen_next     = value_seen;
    digits_stopped_next = digits_stopped;
    emit                = 1'b0;
    push_key            = 1'b0;

    case (phase)
      kvlt_pkg::PH_PREFIX1: begin
        phase_next = (beat.ch == kvlt_pkg::CH_SLASH) ? kvlt_pkg::PH_PREFIX2
                                                     : kvlt_pkg::PH_REJECT;
      end
      kvlt_pkg::PH_PREFIX2: begin
        phase_next = (beat.ch == kvlt_pkg::CH_SLASH) ? kvlt_pkg::PH_BLANKS
                                                     : kvlt_pkg::PH_REJECT;
      end
      kvlt_pkg::PH_BLANKS: begin
        if (beat.ch == kvlt_pkg::CH_SPACE || beat.ch == kvlt_pkg::CH_TAB) begin
          phase_next = kvlt_pkg::PH_BLANKS;
        end else if (beat.ch == kvlt_pkg::CH_EQUAL) begin
          phase_next = kvlt_pkg::PH_DISCARD;
        end else begin
          key_buffer_next   = '0;
          key_count_next    = '0;
          key_overflow_next = 1'b0;
          push_key          = 1'b1;
          phase_next        = kvlt_pkg::PH_KEY;
        end
      end
      kvlt_pkg::PH_KEY: begin
        if (beat.ch == kvlt_pkg::CH_EQUAL) begin
          value_acc_next      = '0;
          value_negative_next = 1'b0;
          value_seen_next     = 1'b0;
          digits_stopped_next = 1'b0;
          phase_next          = kvlt_pkg::PH_VALUE;
        end else if (beat.ch == kvlt_pkg::CH_SPACE) begin
          phase_next = kvlt_pkg::PH_BLANKS;
        end else begin
          push_key = 1'b1;
        end
      end
      kvlt_pkg::PH_DISCARD: begin
        if (beat.ch == kvlt_pkg::CH_SPACE) begin
          phase_next = kvlt_pkg::PH_BLANKS;
        end
      end
      kvlt_pkg::PH_VALUE: begin
        if (beat.ch == kvlt_pkg::CH_SPACE) begin
          emit       = value_seen;
          phase_next = kvlt_pkg::PH_BLANKS;
        end else begin
          if (!value_seen && beat.ch == kvlt_pkg::CH_MINUS) begin
            value_negative_next = 1'b1;
          end else if (!digits_stopped) begin
            if (is_digit) begin
              // times ten as two shifts
              value_acc_next = (value_acc << 3) + (value_acc << 1) + digit_term;
            end else begin
              digits_stopped_next = 1'b1;
            end
          end
          value_seen_next = 1'b1;
        end
      end
      default: begin
        phase_next = kvlt_pkg::PH_REJECT;
      end
    endcase

    if (push_key) begin
      if (key_count_next < kvlt_pkg::LEN_W'(kvlt_pkg::KEY_BYTES)) begin
        for (int i = 0; i < kvlt_pkg::KEY_BYTES; i++) begin
          if (key_count_next == kvlt_pkg::LEN_W'(i)) begin
            key_buffer_next[8*i +: 8] = beat.ch;
          end
        end
      end else begin
        key_overflow_next = 1'b1;
      end
      if (key_count_next != kvlt_pkg::LEN_MAX) begin
        key_count_next = key_count_next + kvlt_pkg::LEN_W'(1);
      end
    end

    if (beat.eol && phase_next == kvlt_pkg::PH_VALUE && value_seen_next) begin
      emit = 1'b1;
    end
  end

  assign accepted = (phase_next == kvlt_pkg::PH_BLANKS) || (phase_next == kvlt_pkg::PH_KEY) ||
                    (phase_next == kvlt_pkg::PH_DISCARD) || (phase_next == kvlt_pkg::PH_VALUE);

  assign produce = emit | beat.eol;

  always_comb begin
    result               = '0;
    result.line_end      = beat.eol;
    result.line_accepted = accepted;
    if (emit) begin
      result.pair_valid    = 1'b1;
      result.key_bytes     = key_buffer_next;
      result.key_length    = key_count_next;
      result.key_truncated = key_overflow_next;
      result.pair_value    = value_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && beat.eol)) begin
      phase          <= kvlt_pkg::PH_PREFIX1;
      key_buffer     <= '0;
      key_count      <= '0;
      key_overflow   <= 1'b0;
      value_acc      <= '0;
      value_negative <= 1'b0;
      value_seen     <= 1'b0;
      digits_stopped <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      key_buffer     <= key_buffer_next;
      key_count      <= key_count_next;
      key_overflow   <= key_overflow_next;
      value_acc      <= value_acc_next;
      value_negative <= value_negative_next;
      value_seen     <= value_seen_next;
      digits_stopped <= digits_stopped_next;
    end
  end

endmodule

@@ rtl/kvlt_out_stage.sv @@
`timescale 1ns / 1ps
// result register: holds one result beat until the sink takes it
// depends on kvlt_pkg

module kvlt_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  kvlt_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              take,
  output kvlt_pkg::result_t result
);

  // room for a new result when empty or when the held one leaves this cycle
  assign take = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

@@ tb/key_value_line_tokenizer_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for key_value_line_tokenizer: queued text lines, a tokenizer predictor
// and a result checker; depends on kvlt_pkg and the key_value_line_tokenizer rtl

module key_value_line_tokenizer_test;
  import kvlt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] char_in = 8'h00;
  logic end_of_line = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic pair_valid;
  logic [63:0] key_bytes;
  logic [7:0] key_length;
  logic key_truncated;
  logic signed [63:0] pair_value;
  logic line_end;
  logic line_accepted;

  key_value_line_tokenizer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .char_in(char_in), .end_of_line(end_of_line),
    .out_valid(out_valid), .out_stall(out_stall),
    .pair_valid(pair_valid), .key_bytes(key_bytes), .key_length(key_length),
    .key_truncated(key_truncated), .pair_value(pair_value),
    .line_end(line_end), .line_accepted(line_accepted)
  );

  always #4 clk = ~clk;

  beat_t pending_beats[$];
  result_t expected_results[$];
  logic [7:0] line_buf[$];

  int errors = 0;
  int bytes_sent = 0;
  int lines_queued = 0;
  int results_seen = 0;
  int pairs_seen = 0;
  int long_keys = 0;

  // tokenizer state as the predictor sees it
  phase_t tk_phase;
  logic [63:0] key_shift;
  logic [7:0] key_len;
  logic key_long;
  logic [63:0] val_mag;
  logic val_neg, val_any, val_done;

  function automatic void clear_parser();
    tk_phase = PH_PREFIX1;
    key_shift = '0;
    key_len = '0;
    key_long = 1'b0;
    val_mag = '0;
    val_neg = 1'b0;
    val_any = 1'b0;
    val_done = 1'b0;
  endfunction

  function automatic void append_key_byte(input logic [7:0] c);
    if (key_len < 8'(KEY_BYTES)) key_shift = key_shift | (64'(c) << {key_len[2:0], 3'b000});
    else key_long = 1'b1;
    if (key_len != LEN_MAX) key_len = key_len + 8'd1;
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic eol);
    logic emit;
    result_t r;
    emit = 1'b0;
    case (tk_phase)
      PH_PREFIX1: tk_phase = (c == CH_SLASH) ? PH_PREFIX2 : PH_REJECT;
      PH_PREFIX2: tk_phase = (c == CH_SLASH) ? PH_BLANKS : PH_REJECT;
      PH_BLANKS: begin
        if (c == CH_EQUAL) begin
          tk_phase = PH_DISCARD;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          key_shift = '0;
          key_len = '0;
          key_long = 1'b0;
          append_key_byte(c);
          tk_phase = PH_KEY;
        end
      end
      PH_KEY: begin
        if (c == CH_EQUAL) begin
          val_mag = '0;
          val_neg = 1'b0;
          val_any = 1'b0;
          val_done = 1'b0;
          tk_phase = PH_VALUE;
        end else if (c == CH_SPACE) begin
          tk_phase = PH_BLANKS;
        end else begin
          append_key_byte(c);
        end
      end
      PH_DISCARD: if (c == CH_SPACE) tk_phase = PH_BLANKS;
      PH_VALUE: begin
        if (c == CH_SPACE) begin
          emit = val_any;
          tk_phase = PH_BLANKS;
        end else begin
          // minus only counts as the very first value byte
          if (!val_any && c == CH_MINUS) val_neg = 1'b1;
          else if (!val_done) begin
            if (c >= CH_ZERO && c <= CH_NINE) val_mag = val_mag * 64'd10 + 64'(c - CH_ZERO);
            else val_done = 1'b1;
          end
          val_any = 1'b1;
        end
      end
      default: tk_phase = PH_REJECT;
    endcase
    if (eol && tk_phase == PH_VALUE && val_any) emit = 1'b1;
    if (emit || eol) begin
      r = '0;
      if (emit) begin
        r.pair_valid = 1'b1;
        r.key_bytes = key_shift;
        r.key_length = key_len;
        r.key_truncated = key_long;
        r.pair_value = val_neg ? 64'd0 - val_mag : val_mag;
      end
      r.line_end = eol;
      r.line_accepted = (tk_phase == PH_BLANKS || tk_phase == PH_KEY ||
                         tk_phase == PH_DISCARD || tk_phase == PH_VALUE);
      expected_results.push_back(r);
    end
    if (eol) clear_parser();
  endfunction

  // stimulus building: bytes collect in line_buf, flush_line marks the last one
  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void flush_line();
    beat_t b;
    for (int i = 0; i < line_buf.size(); i++) begin
      b.ch = line_buf[i];
      b.eol = (i == line_buf.size() - 1);
      pending_beats.push_back(b);
    end
    line_buf.delete();
    lines_queued++;
  endfunction

  function automatic void append_key(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_EQUAL);
      line_buf.push_back(c);
    end
  endfunction

  function automatic void append_value();
    int n;
    logic [7:0] c;
    if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_MINUS);
    // long digit runs wrap the 64-bit accumulator
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 6);
    for (int i = 0; i < n; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_SPACE);
        line_buf.push_back(c);
      end
    end
  endfunction

  function automatic void build_random_line();
    int sel, ntok, n, klen;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (sel == 1) begin
      line_buf.push_back(CH_SLASH);
      line_buf.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_EQUAL);
      append_key($urandom_range(0, 4));
    end else begin
      append_text("//");
      ntok = $urandom_range(0, 5);
      for (int t = 0; t < ntok; t++) begin
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 2);
          for (int i = 0; i < n; i++)
            line_buf.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
        end
        if (long_keys < 3 && $urandom_range(0, 80) == 0) begin
          klen = $urandom_range(250, 300);
          long_keys++;
        end else begin
          klen = $urandom_range(1, 11);
        end
        sel = $urandom_range(0, 15);
        case (sel)
          0: append_key(klen);
          1: begin
            line_buf.push_back(CH_EQUAL);
            append_value();
          end
          2: begin
            append_key(klen);
            line_buf.push_back(CH_EQUAL);
          end
          3: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            append_key(klen);
            line_buf.push_back(CH_EQUAL);
            append_value();
          end
        endcase
        if (t < ntok - 1 || $urandom_range(0, 3) == 0) begin
          line_buf.push_back(CH_SPACE);
          if ($urandom_range(0, 5) == 0) line_buf.push_back(CH_SPACE);
        end
      end
    end
    flush_line();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 40)
      $display("mismatch at %0t: %0s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // sender: bursts of back-to-back beats, random gaps between bursts
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(char_in, end_of_line);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          char_in <= b.ch;
          end_of_line <= b.eol;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall behavior switches between free-running, random, periodic and long holds
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.pair_valid = pair_valid;
        got.key_bytes = key_bytes;
        got.key_length = key_length;
        got.key_truncated = key_truncated;
        got.pair_value = pair_value;
        got.line_end = line_end;
        got.line_accepted = line_accepted;
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", got.key_bytes, '0);
        end else begin
          want = expected_results.pop_front();
          if (want.pair_valid) pairs_seen++;
          if (got.pair_valid !== want.pair_valid)
            report_mismatch("pair_valid", 64'(got.pair_valid), 64'(want.pair_valid));
          if (got.key_bytes !== want.key_bytes)
            report_mismatch("key_bytes", got.key_bytes, want.key_bytes);
          if (got.key_length !== want.key_length)
            report_mismatch("key_length", 64'(got.key_length), 64'(want.key_length));
          if (got.key_truncated !== want.key_truncated)
            report_mismatch("key_truncated", 64'(got.key_truncated),
                            64'(want.key_truncated));
          if (got.pair_value !== want.pair_value)
            report_mismatch("pair_value", got.pair_value, want.pair_value);
          if (got.line_end !== want.line_end)
            report_mismatch("line_end", 64'(got.line_end), 64'(want.line_end));
          if (got.line_accepted !== want.line_accepted)
            report_mismatch("line_accepted", 64'(got.line_accepted),
                            64'(want.line_accepted));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (stall_tick % 7 < 3);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(4, 20);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  initial begin
    int directed_bytes;
    clear_parser();
    append_text("x");
    flush_line();
    append_text("/");
    flush_line();
    append_text("/x=1");
    flush_line();
    // blanks, empty key, bare token, bytes after digits, empty value, lone minus at line end
    append_text("//\t=z c ab=7=- d= e=-");
    flush_line();
    append_text("//");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    append_text("abcdefg=9");
    flush_line();
    directed_bytes = pending_beats.size();
    while (pending_beats.size() < directed_bytes + 1000) build_random_line();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d lines, %0d long keys", bytes_sent, lines_queued, long_keys);
    $display("checked %0d result beats, %0d of them with a pair", results_seen, pairs_seen);
    if (errors == 0) begin
      $display("key_value_line_tokenizer regression: pass");
    end else begin
      $display("key_value_line_tokenizer regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d beats still queued", pending_beats.size());
    $display("key_value_line_tokenizer regression: fail");
    $finish;
  end

endmodule
